/* rtl/dec_pkg.sv */
// Package for the disc collision pipeline: widths, stage map, payload types, helpers.
package dec_pkg;

	localparam int FRAC     = 16;
	localparam int SQ_STEPS = 32;
	localparam int NQ_W     = FRAC + 1;
	localparam int NR_W     = 32 + FRAC;
	localparam int N_W      = FRAC + 2;
	localparam int S_W      = 35;
	localparam int NUM_W    = 56;
	localparam int MQ_W     = 35;
	localparam int DV_W     = 37;

	localparam int ST_IN    = 0;
	localparam int ST_SQ    = ST_IN + 1;
	localparam int ST_CMP   = ST_SQ + 1;
	localparam int ST_SQRT0 = ST_CMP + 1;
	localparam int ST_PUSH  = ST_SQRT0 + SQ_STEPS;
	localparam int ST_DIVN0 = ST_PUSH + 1;
	localparam int ST_NRM   = ST_DIVN0 + NQ_W;
	localparam int ST_MUL1  = ST_NRM + 1;
	localparam int ST_SUM1  = ST_MUL1 + 1;
	localparam int ST_S     = ST_SUM1 + 1;
	localparam int ST_MUL2  = ST_S + 1;
	localparam int ST_NUM   = ST_MUL2 + 1;
	localparam int ST_MAG   = ST_NUM + 1;
	localparam int ST_DIVM0 = ST_MAG + 1;
	localparam int ST_D     = ST_DIVM0 + MQ_W;
	localparam int ST_MUL3  = ST_D + 1;
	localparam int ST_OUT   = ST_MUL3 + 1;
	localparam int NSTG     = ST_OUT + 1;

	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] avx;
		logic signed [31:0] avy;
		logic [30:0]        arad;
		logic [15:0]        amass;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bvx;
		logic signed [31:0] bvy;
		logic [30:0]        brad;
		logic [15:0]        bmass;
	} in_t;

	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] avx;
		logic signed [31:0] avy;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bvx;
		logic signed [31:0] bvy;
		logic               hit;
	} out_t;

	typedef struct packed {
		logic signed [31:0]            ax;
		logic signed [31:0]            ay;
		logic signed [31:0]            avx;
		logic signed [31:0]            avy;
		logic signed [31:0]            bx;
		logic signed [31:0]            by;
		logic signed [31:0]            bvx;
		logic signed [31:0]            bvy;
		logic [31:0]                   rs;
		logic [15:0]                   m1;
		logic [15:0]                   m2;
		logic                          sgx;
		logic                          sgy;
		logic                          cand;
		logic                          hit;
		logic [31:0]                   adx;
		logic [31:0]                   ady;
		logic [63:0]                   sx;
		logic [63:0]                   sy;
		logic [63:0]                   rr;
		logic [63:0]                   sqx;
		logic [63:0]                   sqr;
		logic [31:0]                   push;
		logic [NR_W-1:0]               remx;
		logic [NR_W-1:0]               remy;
		logic [NQ_W-1:0]               qx;
		logic [NQ_W-1:0]               qy;
		logic signed [N_W-1:0]         nx;
		logic signed [N_W-1:0]         ny;
		logic [NQ_W+31:0]              px;
		logic [NQ_W+31:0]              py;
		logic signed [N_W+31:0]        pa1;
		logic signed [N_W+31:0]        pa2;
		logic signed [N_W+31:0]        pb1;
		logic signed [N_W+31:0]        pb2;
		logic signed [N_W+32:0]        sum1;
		logic signed [N_W+32:0]        sum2;
		logic signed [33:0]            mx;
		logic signed [33:0]            my;
		logic signed [31:0]            axo;
		logic signed [31:0]            ayo;
		logic signed [31:0]            bxo;
		logic signed [31:0]            byo;
		logic signed [S_W-1:0]         s1;
		logic signed [S_W-1:0]         s2;
		logic [16:0]                   msum;
		logic signed [NUM_W-1:0]       t1a;
		logic signed [NUM_W-1:0]       t1b;
		logic signed [NUM_W-1:0]       t2a;
		logic signed [NUM_W-1:0]       t2b;
		logic signed [NUM_W-1:0]       num1;
		logic signed [NUM_W-1:0]       num2;
		logic                          ng1;
		logic                          ng2;
		logic [NUM_W-1:0]              r1;
		logic [NUM_W-1:0]              r2;
		logic [MQ_W-1:0]               q1;
		logic [MQ_W-1:0]               q2;
		logic signed [DV_W-1:0]        d1;
		logic signed [DV_W-1:0]        d2;
		logic signed [DV_W+N_W-1:0]    e1x;
		logic signed [DV_W+N_W-1:0]    e1y;
		logic signed [DV_W+N_W-1:0]    e2x;
		logic signed [DV_W+N_W-1:0]    e2y;
		logic signed [31:0]            avxo;
		logic signed [31:0]            avyo;
		logic signed [31:0]            bvxo;
		logic signed [31:0]            bvyo;
	} pl_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	// divide by 2^FRAC, rounding toward zero
	function automatic logic signed [63:0] trunc_frac(input logic signed [63:0] v);
		logic signed [63:0] m;
		m = (v < 0) ? -v : v;
		m = m >>> FRAC;
		return (v < 0) ? -m : m;
	endfunction

endpackage

/* rtl/dec_datapath.sv */
// Collision datapath: square, root, normal division, momentum exchange, saturation.
module dec_datapath (
	input  logic         clk,
	input  logic         en,
	input  dec_pkg::in_t din,
	output dec_pkg::out_t dout
);
	import dec_pkg::*;

	pl_t pipe_s [NSTG];

	for (genvar k = 0; k < NSTG; k++) begin : g_st
		pl_t nxt;

		if (k == ST_IN) begin : g_in
			always_comb begin
				logic signed [32:0] dx;
				logic signed [32:0] dy;
				nxt = '0;
				dx = 33'(din.ax) - 33'(din.bx);
				dy = 33'(din.ay) - 33'(din.by);
				nxt.ax = din.ax;
				nxt.ay = din.ay;
				nxt.avx = din.avx;
				nxt.avy = din.avy;
				nxt.bx = din.bx;
				nxt.by = din.by;
				nxt.bvx = din.bvx;
				nxt.bvy = din.bvy;
				nxt.m1 = din.amass;
				nxt.m2 = din.bmass;
				nxt.sgx = dx[32];
				nxt.sgy = dy[32];
				nxt.adx = dx[32] ? 32'(-dx) : dx[31:0];
				nxt.ady = dy[32] ? 32'(-dy) : dy[31:0];
				nxt.rs = 32'(din.arad) + 32'(din.brad);
				nxt.cand = ((nxt.adx | nxt.ady) != 32'd0) && (nxt.adx <= nxt.rs)
					&& (nxt.ady <= nxt.rs);
			end
		end else begin : g_op
			always_comb begin
				logic [63:0]       sbit;
				logic [63:0]       stry;
				logic [64:0]       s65;
				logic [NR_W-1:0]   dshn;
				logic [NUM_W-1:0]  dshm;
				logic [15:0]       m1e;
				logic [15:0]       m2e;
				logic signed [16:0] md;
				logic signed [18:0] tw1;
				logic signed [18:0] tw2;
				sbit = '0;
				stry = '0;
				s65 = '0;
				dshn = '0;
				dshm = '0;
				m1e = '0;
				m2e = '0;
				md = '0;
				tw1 = '0;
				tw2 = '0;
				nxt = pipe_s[k-1];
				if (k == ST_SQ) begin
					nxt.sx = nxt.adx * nxt.adx;
					nxt.sy = nxt.ady * nxt.ady;
					nxt.rr = nxt.rs * nxt.rs;
				end else if (k == ST_CMP) begin
					s65 = {1'b0, nxt.sx} + {1'b0, nxt.sy};
					nxt.hit = nxt.cand && !s65[64] && (s65[63:0] <= nxt.rr);
					nxt.sqx = s65[63:0];
					nxt.sqr = '0;
				end else if (k >= ST_SQRT0 && k < ST_PUSH) begin
					sbit = 64'(1) << (62 - 2 * (k - ST_SQRT0));
					stry = nxt.sqr + sbit;
					if (nxt.sqx >= stry) begin
						nxt.sqx = nxt.sqx - stry;
						nxt.sqr = (nxt.sqr >> 1) + sbit;
					end else begin
						nxt.sqr = nxt.sqr >> 1;
					end
				end else if (k == ST_PUSH) begin
					nxt.push = (nxt.rs - nxt.sqr[31:0]) >> 1;
					nxt.remx = {nxt.adx, {FRAC{1'b0}}};
					nxt.remy = {nxt.ady, {FRAC{1'b0}}};
					nxt.qx = '0;
					nxt.qy = '0;
				end else if (k >= ST_DIVN0 && k < ST_NRM) begin
					dshn = NR_W'(nxt.sqr[31:0]) << (ST_NRM - 1 - k);
					nxt.qx = {nxt.qx[NQ_W-2:0], nxt.remx >= dshn};
					nxt.qy = {nxt.qy[NQ_W-2:0], nxt.remy >= dshn};
					if (nxt.remx >= dshn)
						nxt.remx = nxt.remx - dshn;
					if (nxt.remy >= dshn)
						nxt.remy = nxt.remy - dshn;
				end else if (k == ST_NRM) begin
					nxt.nx = nxt.sgx ? -N_W'(nxt.qx) : N_W'(nxt.qx);
					nxt.ny = nxt.sgy ? -N_W'(nxt.qy) : N_W'(nxt.qy);
				end else if (k == ST_MUL1) begin
					nxt.px = nxt.qx * nxt.push;
					nxt.py = nxt.qy * nxt.push;
					nxt.pa1 = nxt.avx * nxt.nx;
					nxt.pa2 = nxt.avy * nxt.ny;
					nxt.pb1 = nxt.bvx * nxt.nx;
					nxt.pb2 = nxt.bvy * nxt.ny;
				end else if (k == ST_SUM1) begin
					nxt.mx = nxt.sgx ? -34'(nxt.px >> FRAC) : 34'(nxt.px >> FRAC);
					nxt.my = nxt.sgy ? -34'(nxt.py >> FRAC) : 34'(nxt.py >> FRAC);
					nxt.sum1 = nxt.pa1 + nxt.pa2;
					nxt.sum2 = nxt.pb1 + nxt.pb2;
				end else if (k == ST_S) begin
					nxt.s1 = S_W'(trunc_frac(64'(nxt.sum1)));
					nxt.s2 = S_W'(trunc_frac(64'(nxt.sum2)));
					nxt.axo = sat32(64'(nxt.ax) + 64'(nxt.mx));
					nxt.ayo = sat32(64'(nxt.ay) + 64'(nxt.my));
					nxt.bxo = sat32(64'(nxt.bx) - 64'(nxt.mx));
					nxt.byo = sat32(64'(nxt.by) - 64'(nxt.my));
				end else if (k == ST_MUL2) begin
					m1e = nxt.m1;
					m2e = nxt.m2;
					if (m1e == 16'd0 && m2e == 16'd0) begin
						m1e = 16'd1;
						m2e = 16'd1;
					end
					md = $signed({1'b0, m1e}) - $signed({1'b0, m2e});
					tw1 = $signed({2'b00, m1e, 1'b0});
					tw2 = $signed({2'b00, m2e, 1'b0});
					nxt.msum = {1'b0, m1e} + {1'b0, m2e};
					nxt.t1a = nxt.s1 * md;
					nxt.t1b = nxt.s2 * tw2;
					nxt.t2a = nxt.s2 * (-md);
					nxt.t2b = nxt.s1 * tw1;
				end else if (k == ST_NUM) begin
					nxt.num1 = nxt.t1a + nxt.t1b;
					nxt.num2 = nxt.t2a + nxt.t2b;
				end else if (k == ST_MAG) begin
					nxt.ng1 = nxt.num1[NUM_W-1];
					nxt.ng2 = nxt.num2[NUM_W-1];
					nxt.r1 = nxt.ng1 ? NUM_W'(-nxt.num1) : NUM_W'(nxt.num1);
					nxt.r2 = nxt.ng2 ? NUM_W'(-nxt.num2) : NUM_W'(nxt.num2);
					nxt.q1 = '0;
					nxt.q2 = '0;
				end else if (k >= ST_DIVM0 && k < ST_D) begin
					dshm = NUM_W'(nxt.msum) << (ST_D - 1 - k);
					nxt.q1 = {nxt.q1[MQ_W-2:0], nxt.r1 >= dshm};
					nxt.q2 = {nxt.q2[MQ_W-2:0], nxt.r2 >= dshm};
					if (nxt.r1 >= dshm)
						nxt.r1 = nxt.r1 - dshm;
					if (nxt.r2 >= dshm)
						nxt.r2 = nxt.r2 - dshm;
				end else if (k == ST_D) begin
					nxt.d1 = (nxt.ng1 ? -DV_W'(nxt.q1) : DV_W'(nxt.q1)) - DV_W'(nxt.s1);
					nxt.d2 = (nxt.ng2 ? -DV_W'(nxt.q2) : DV_W'(nxt.q2)) - DV_W'(nxt.s2);
				end else if (k == ST_MUL3) begin
					nxt.e1x = nxt.d1 * nxt.nx;
					nxt.e1y = nxt.d1 * nxt.ny;
					nxt.e2x = nxt.d2 * nxt.nx;
					nxt.e2y = nxt.d2 * nxt.ny;
				end else if (k == ST_OUT) begin
					if (nxt.hit) begin
						nxt.avxo = sat32(64'(nxt.avx) + trunc_frac(64'(nxt.e1x)));
						nxt.avyo = sat32(64'(nxt.avy) + trunc_frac(64'(nxt.e1y)));
						nxt.bvxo = sat32(64'(nxt.bvx) + trunc_frac(64'(nxt.e2x)));
						nxt.bvyo = sat32(64'(nxt.bvy) + trunc_frac(64'(nxt.e2y)));
					end else begin
						nxt.axo = nxt.ax;
						nxt.ayo = nxt.ay;
						nxt.bxo = nxt.bx;
						nxt.byo = nxt.by;
						nxt.avxo = nxt.avx;
						nxt.avyo = nxt.avy;
						nxt.bvxo = nxt.bvx;
						nxt.bvyo = nxt.bvy;
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en)
				pipe_s[k] <= nxt;
		end
	end

	assign dout.ax  = pipe_s[NSTG-1].axo;
	assign dout.ay  = pipe_s[NSTG-1].ayo;
	assign dout.avx = pipe_s[NSTG-1].avxo;
	assign dout.avy = pipe_s[NSTG-1].avyo;
	assign dout.bx  = pipe_s[NSTG-1].bxo;
	assign dout.by  = pipe_s[NSTG-1].byo;
	assign dout.bvx = pipe_s[NSTG-1].bvxo;
	assign dout.bvy = pipe_s[NSTG-1].bvyo;
	assign dout.hit = pipe_s[NSTG-1].hit;

endmodule

/* rtl/disc_elastic_collision_top.sv */
// Top level of the two-disc elastic collision pipeline with valid/ready flow control.
// Takes one disc pair per cycle while the output is not stalled, and returns one result
// per pair, in order. Between acceptance and the output transaction the pair passes
// through NSTG = 98 register stages. The depth is set by the 32-step square root of the
// squared center distance, the 17-step divider that forms the unit normal, and the 35-step
// divider by the mass sum; each step is one stage. When the output transaction is not
// taken, the whole pipeline holds, so in_ready is low only while a result waits.
module disc_elastic_collision_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] avx,
	input  logic signed [31:0] avy,
	input  logic [30:0]        arad,
	input  logic [15:0]        amass,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by,
	input  logic signed [31:0] bvx,
	input  logic signed [31:0] bvy,
	input  logic [30:0]        brad,
	input  logic [15:0]        bmass,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] ax_out,
	output logic signed [31:0] ay_out,
	output logic signed [31:0] avx_out,
	output logic signed [31:0] avy_out,
	output logic signed [31:0] bx_out,
	output logic signed [31:0] by_out,
	output logic signed [31:0] bvx_out,
	output logic signed [31:0] bvy_out,
	output logic               hit
);
	import dec_pkg::*;

	logic            adv;
	logic [NSTG-1:0] vld_s;
	in_t             din;
	out_t            dout;

	assign adv = !vld_s[NSTG-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_s[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (adv)
			vld_s <= {vld_s[NSTG-2:0], in_valid};
	end

	assign din.ax = ax;
	assign din.ay = ay;
	assign din.avx = avx;
	assign din.avy = avy;
	assign din.arad = arad;
	assign din.amass = amass;
	assign din.bx = bx;
	assign din.by = by;
	assign din.bvx = bvx;
	assign din.bvy = bvy;
	assign din.brad = brad;
	assign din.bmass = bmass;

	dec_datapath u_dp (
		.clk  (clk),
		.en   (adv),
		.din  (din),
		.dout (dout)
	);

	assign ax_out = dout.ax;
	assign ay_out = dout.ay;
	assign avx_out = dout.avx;
	assign avy_out = dout.avy;
	assign bx_out = dout.bx;
	assign by_out = dout.by;
	assign bvx_out = dout.bvx;
	assign bvy_out = dout.bvy;
	assign hit = dout.hit;

endmodule

/* rtl/dec_check.sv */
// Port-level checker for the disc collision top level, bound to it.
module dec_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] ax_out,
	input logic               hit
);

	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> (in_ready == (!out_valid || out_ready)))
		else $error("in_ready does not follow output backpressure");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result shown during reset");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(ax_out) && $stable(hit))
		else $error("result payload changed while stalled");

endmodule

bind disc_elastic_collision_top dec_check u_chk (.*);

/* tb/disc_elastic_collision_top_tb.sv */
// Testbench for the two-disc collision pipeline: table-driven and random pairs, checked by a predictor.
`timescale 1ns / 1ps

module disc_elastic_collision_top_tb;
	import dec_pkg::*;

	localparam longint ONE = 64'sd1 << FRAC;
	localparam longint LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] ax, ay, avx, avy, bx, by, bvx, bvy;
	logic [30:0] arad, brad;
	logic [15:0] amass, bmass;
	logic signed [31:0] ax_out, ay_out, avx_out, avy_out, bx_out, by_out, bvx_out, bvy_out;
	logic hit;

	typedef struct {
		in_t pair;
		logic fixed;
		out_t want;
	} row_t;

	out_t pending[$];
	row_t dir_rows[$];
	int errors;
	longint cycles;
	bit stim_done;

	disc_elastic_collision_top DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.ax(ax), .ay(ay), .avx(avx), .avy(avy), .arad(arad), .amass(amass),
		.bx(bx), .by(by), .bvx(bvx), .bvy(bvy), .brad(brad), .bmass(bmass),
		.out_valid(out_valid), .out_ready(out_ready),
		.ax_out(ax_out), .ay_out(ay_out), .avx_out(avx_out), .avy_out(avy_out),
		.bx_out(bx_out), .by_out(by_out), .bvx_out(bvx_out), .bvy_out(bvy_out),
		.hit(hit)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint unsigned root64(longint unsigned x);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic out_t collide(in_t p);
		out_t o;
		longint dx, dy, nx, ny, mx, my, s1, s2, m1, m2, msum, n1, n2, d1, d2, push;
		longint unsigned adx, ady, rs, sx, sy, s, dlen;
		longint r[8];
		r[0] = p.ax; r[1] = p.ay; r[2] = p.avx; r[3] = p.avy;
		r[4] = p.bx; r[5] = p.by; r[6] = p.bvx; r[7] = p.bvy;
		o.hit = 0;
		m1 = p.amass;
		m2 = p.bmass;
		dx = longint'(p.ax) - longint'(p.bx);
		dy = longint'(p.ay) - longint'(p.by);
		adx = abs64(dx);
		ady = abs64(dy);
		rs = longint'(p.arad) + longint'(p.brad);
		if ((adx | ady) != 0 && adx <= rs && ady <= rs) begin
			sx = adx * adx;
			sy = ady * ady;
			s = sx + sy;
			if (s >= sx && s <= rs * rs) begin
				dlen = root64(s);
				push = (rs - dlen) >> 1;
				nx = (adx * ONE) / dlen;
				ny = (ady * ONE) / dlen;
				if (dx < 0) nx = -nx;
				if (dy < 0) ny = -ny;
				o.hit = 1;
				mx = nx * push / ONE;
				my = ny * push / ONE;
				r[0] += mx; r[1] += my; r[4] -= mx; r[5] -= my;
				s1 = (longint'(p.avx) * nx + longint'(p.avy) * ny) / ONE;
				s2 = (longint'(p.bvx) * nx + longint'(p.bvy) * ny) / ONE;
				if (m1 + m2 == 0) begin
					m1 = 1;
					m2 = 1;
				end
				msum = m1 + m2;
				n1 = (s1 * (m1 - m2) + 2 * m2 * s2) / msum;
				n2 = (s2 * (m2 - m1) + 2 * m1 * s1) / msum;
				d1 = n1 - s1;
				d2 = n2 - s2;
				r[2] += d1 * nx / ONE; r[3] += d1 * ny / ONE;
				r[6] += d2 * nx / ONE; r[7] += d2 * ny / ONE;
			end
		end
		o.ax = clamp32(r[0]); o.ay = clamp32(r[1]); o.avx = clamp32(r[2]);
		o.avy = clamp32(r[3]); o.bx = clamp32(r[4]); o.by = clamp32(r[5]);
		o.bvx = clamp32(r[6]); o.bvy = clamp32(r[7]);
		return o;
	endfunction

	function automatic in_t mk(int x1, int y1, int vx1, int vy1, int r1, int m1,
			int x2, int y2, int vx2, int vy2, int r2, int m2);
		in_t p;
		p.ax = x1; p.ay = y1; p.avx = vx1; p.avy = vy1; p.arad = 31'(r1); p.amass = 16'(m1);
		p.bx = x2; p.by = y2; p.bvx = vx2; p.bvy = vy2; p.brad = 31'(r2); p.bmass = 16'(m2);
		return p;
	endfunction

	function automatic out_t passed(in_t p);
		out_t o;
		o.ax = p.ax; o.ay = p.ay; o.avx = p.avx; o.avy = p.avy;
		o.bx = p.bx; o.by = p.by; o.bvx = p.bvx; o.bvy = p.bvy; o.hit = 0;
		return o;
	endfunction

	task automatic add_row(in_t p, logic fixed);
		row_t rw;
		rw.pair = p;
		rw.fixed = fixed;
		rw.want = fixed ? passed(p) : collide(p);
		dir_rows.push_back(rw);
	endtask

	function automatic int rnd32();
		return $urandom;
	endfunction

	function automatic in_t rand_pair();
		in_t p;
		int span, mode;
		mode = $urandom_range(0, 9);
		p.avx = rnd32(); p.avy = rnd32(); p.bvx = rnd32(); p.bvy = rnd32();
		if ($urandom_range(0, 2) != 0) begin
			p.avx = $signed(p.avx) >>> $urandom_range(0, 20);
			p.avy = $signed(p.avy) >>> $urandom_range(0, 20);
			p.bvx = $signed(p.bvx) >>> $urandom_range(0, 20);
			p.bvy = $signed(p.bvy) >>> $urandom_range(0, 20);
		end
		p.amass = 16'($urandom); p.bmass = 16'($urandom);
		if ($urandom_range(0, 3) == 0) p.amass = 16'($urandom_range(0, 4));
		if ($urandom_range(0, 3) == 0) p.bmass = 16'($urandom_range(0, 4));
		if (mode == 0) begin
			p.ax = rnd32(); p.ay = rnd32(); p.bx = rnd32(); p.by = rnd32();
			p.arad = 31'($urandom); p.brad = 31'($urandom);
		end else begin
			span = 1 << $urandom_range(2, 30);
			p.arad = 31'($urandom_range(0, span));
			p.brad = 31'($urandom_range(0, span));
			p.ax = rnd32();
			p.ay = rnd32();
			if (mode == 1) begin
				p.bx = p.ax;
				p.by = p.ay;
			end else begin
				p.bx = p.ax + int'($urandom_range(0, 2 * span)) - span;
				p.by = p.ay + int'($urandom_range(0, 2 * span)) - span;
			end
		end
		return p;
	endfunction

	task automatic send(in_t p);
		int idle;
		idle = $urandom_range(0, 6);
		if (idle > 0) begin
			in_valid <= 0;
			repeat (idle) @(posedge clk);
		end
		ax <= p.ax; ay <= p.ay; avx <= p.avx; avy <= p.avy; arad <= p.arad;
		amass <= p.amass; bx <= p.bx; by <= p.by; bvx <= p.bvx; bvy <= p.bvy;
		brad <= p.brad; bmass <= p.bmass;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
	endtask

	initial begin
		in_valid = 0;
		ax = 0; ay = 0; avx = 0; avy = 0; arad = 0; amass = 0;
		bx = 0; by = 0; bvx = 0; bvy = 0; brad = 0; bmass = 0;
		stim_done = 0;
		arst_n = 1;
		#0.5;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
		add_row(mk(5 << 16, 5 << 16, 1 << 16, -1 << 16, 31'h7fffffff, 1,
			5 << 16, 5 << 16, 3, 4, 31'h7fffffff, 1), 1);
		add_row(mk(32'sh7fffffff, 32'sh7fffffff, 7, 8, 0, 3,
			32'sh80000000, 32'sh80000000, 9, 10, 0, 3), 1);
		add_row(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
			31'h7fffffff, 65535, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 31'h7fffffff, 65535), 0);
		add_row(mk(0, 0, 1 << 16, 0, 1 << 16, 1, 1 << 16, 0, -1 << 16, 0, 1 << 16, 1), 0);
		add_row(mk(0, 0, 1 << 16, 0, 1 << 16, 0, 1 << 16, 0, -1 << 16, 0, 1 << 16, 0), 0);
		add_row(mk(0, 0, 1 << 16, 2 << 16, 1 << 16, 0, 1 << 16, 1 << 16, 0, 0, 1 << 16, 5), 0);
		add_row(mk(0, 0, 3 << 16, 0, 1 << 16, 65535, 3 << 15, 1 << 15, -2 << 16, 0,
			1 << 16, 1), 0);
		add_row(mk(0, 0, 0, 0, 1, 2, 2, 0, 0, 0, 1, 2), 0);
		add_row(mk(0, 0, 0, 0, 1, 2, 3, 0, 0, 0, 1, 2), 0);
		add_row(mk(32'sh7fff0000, 0, 32'sh7fffffff, 0, 31'h40000000, 1,
			32'sh7fff0000 - 100, 0, 32'sh80000000, 0, 31'h40000000, 65535), 0);
		add_row(mk(-5, -7, -1, 1, 20, 9, 5, 7, 1, -1, 20, 4), 0);
		foreach (dir_rows[i]) begin
			pending.push_back(dir_rows[i].want);
			send(dir_rows[i].pair);
		end
		repeat (1900) begin
			in_t p;
			p = rand_pair();
			pending.push_back(collide(p));
			send(p);
		end
		in_valid <= 0;
		stim_done = 1;
	end

	initial begin
		int idle;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			idle = $urandom_range(0, 6);
			if (idle > 0) begin
				out_ready <= 0;
				repeat (idle) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			out_t w, g;
			g = '{ax_out, ay_out, avx_out, avy_out, bx_out, by_out, bvx_out, bvy_out, hit};
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: transaction with nothing expected: %p", $time, g);
			end else begin
				w = pending.pop_front();
				if (g !== w) begin
					errors++;
					$display("%0t: mismatch expected %p actual %p", $time, w, g);
				end
			end
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		while (!(stim_done && pending.size() == 0) && cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= LIMIT) begin
			$display("disc_elastic_collision_top_tb: FAIL");
			$finish;
		end else begin
			repeat (NSTG + 20) @(posedge clk);
			if (errors == 0)
				$display("disc_elastic_collision_top_tb: PASS");
			else
				$display("disc_elastic_collision_top_tb: FAIL");
			$finish;
		end
	end

endmodule
